/* rtl/core/crcrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_pkg
// shared types, constants and the byte-wise crc-32 step for the record decoder
// ----------------------------------------------------------------------------
package crcrd_pkg;

  localparam int unsigned RECORD_BYTES = 32;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned IDX_W        = $clog2(RECORD_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;
  localparam logic [POS_W-1:0] POS_LAST = 6'(RECORD_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_AT  = 6'd28;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] REC_MAGIC  = 32'h3143_5357;
  localparam logic [7:0]  REC_VERSION = 8'd1;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CODE_ENABLED        = 2'd0,
    CFG_CODE_PAUSED_FOREVER = 2'd1,
    CFG_CODE_PAUSED_UNTIL   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] enabled;
    logic [7:0] paused_forever;
    logic [7:0] paused_until;
  } mode_codes_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic        record_ok;
    logic [7:0]  mode_code;
    logic [31:0] resume_epoch;
    logic [31:0] current_day;
    logic [31:0] current_mask;
    logic [31:0] previous_day;
    logic [31:0] previous_mask;
  } result_t;

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/crc32_record_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_record_decoder
// checks a 32-byte state record streamed one byte per word and unpacks it
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | accepted when
//  in_     | in  | tdata[7:0] byte_value, tlast last_byte    | tvalid & tready
//  out_    | out | tuser record_ok, tdata mode + five words  | tvalid & tready
//  cfg_    | in  | addr = register index, wdata = mode code  | we high
//
//  one input word per cycle sustained unless stalled; once its last byte is
//  accepted, a result passes the input register, then the result register
//  crc is one byte per cycle while bytes advance, eight unrolled shift steps in the core
//  rst_n is synchronous; it clears position, crc and valids and returns the
//  mode codes to their reset values
//  input stalls only while a last byte sits in the input register and the
//  result register is full and not being taken
// ----------------------------------------------------------------------------
module crc32_record_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: [7:0] byte_value
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,
  input  wire logic                             in_tlast,
  // out_tdata: [7:0] mode_code, [39:8] resume_epoch, [71:40] current_day,
  //   [103:72] current_mask, [135:104] previous_day, [167:136] previous_mask
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [167:0]                          out_tdata,
  // out_tuser: [0] record_ok
  output logic [0:0]                            out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [crcrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [crcrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  crcrd_pkg::mode_codes_t codes;
  crcrd_pkg::beat_t       in_beat, s1_beat;
  crcrd_pkg::result_t     res, out_res;
  logic                   s1_valid, advance, can_load, res_valid;

  assign in_beat.byte_value = in_tdata;
  assign in_beat.last_byte  = in_tlast;

  // a non-last byte never needs the result register
  assign advance = s1_valid && (!s1_beat.last_byte || can_load);

  crcrd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .codes     (codes)
  );

  crcrd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_beat  (in_beat),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  crcrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .beat      (s1_beat),
    .codes     (codes),
    .res_valid (res_valid),
    .res       (res)
  );

  crcrd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.record_ok;
  assign out_tdata = {out_res.previous_mask, out_res.previous_day, out_res.current_mask,
                      out_res.current_day, out_res.resume_epoch, out_res.mode_code};

endmodule
`default_nettype wire

/* rtl/core/crcrd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_cfg_regs
// mode code registers behind the plain write port
// ----------------------------------------------------------------------------
module crcrd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [crcrd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [crcrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output crcrd_pkg::mode_codes_t                codes
);

  crcrd_pkg::mode_codes_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.enabled        <= 8'd0;
      codes_r.paused_forever <= 8'd1;
      codes_r.paused_until   <= 8'd2;
    end else if (cfg_we) begin
      case (crcrd_pkg::cfg_reg_t'(cfg_addr))
        crcrd_pkg::CFG_CODE_ENABLED:        codes_r.enabled        <= cfg_wdata;
        crcrd_pkg::CFG_CODE_PAUSED_FOREVER: codes_r.paused_forever <= cfg_wdata;
        crcrd_pkg::CFG_CODE_PAUSED_UNTIL:   codes_r.paused_until   <= cfg_wdata;
        default: ; // unused index
      endcase
    end
  end

  assign codes = codes_r;

endmodule
`default_nettype wire

/* rtl/core/crcrd_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_in_reg
// input register stage, refills in the cycle it drains
// ----------------------------------------------------------------------------
module crcrd_in_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire crcrd_pkg::beat_t in_beat,
  input  wire logic             advance,
  output logic                  s1_valid,
  output crcrd_pkg::beat_t      s1_beat
);

  logic             valid_r;
  crcrd_pkg::beat_t beat_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule
`default_nettype wire

/* rtl/core/crcrd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_core
// byte position, running crc, record bytes and the record checks
// ----------------------------------------------------------------------------
module crcrd_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire crcrd_pkg::beat_t       beat,
  input  wire crcrd_pkg::mode_codes_t codes,
  output logic                        res_valid,
  output crcrd_pkg::result_t          res
);

  logic [crcrd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]                 crc_r, crc_nxt;
  logic [7:0]                  store_r [crcrd_pkg::RECORD_BYTES];

  logic [7:0]  rb [crcrd_pkg::RECORD_BYTES];
  logic [31:0] magic_w, crc_w, epoch_w;
  logic        len_ok, hdr_ok, crc_ok, mode_ok;

  // state update
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (fire) begin
      if (pos_r < crcrd_pkg::CRC_AT) begin
        crc_nxt = crcrd_pkg::crc_byte(crc_r, beat.byte_value);
      end
      if (pos_r < crcrd_pkg::POS_MAX) begin
        pos_nxt = pos_r + 6'd1;
      end
      if (beat.last_byte) begin
        pos_nxt = '0;
        crc_nxt = crcrd_pkg::CRC_PRESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= crcrd_pkg::CRC_PRESET;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (pos_r < 6'(crcrd_pkg::RECORD_BYTES))) begin
      store_r[pos_r[crcrd_pkg::IDX_W-1:0]] <= beat.byte_value;
    end
  end

  // record view: final byte comes straight from the arriving word
  always_comb begin
    for (int i = 0; i < crcrd_pkg::RECORD_BYTES - 1; i++) begin
      rb[i] = store_r[i];
    end
    rb[crcrd_pkg::RECORD_BYTES-1] = beat.byte_value;
  end

  assign magic_w = {rb[3], rb[2], rb[1], rb[0]};
  assign epoch_w = {rb[11], rb[10], rb[9], rb[8]};
  assign crc_w   = {rb[31], rb[30], rb[29], rb[28]};

  assign len_ok = (pos_r == crcrd_pkg::POS_LAST);
  assign hdr_ok = (magic_w == crcrd_pkg::REC_MAGIC) && (rb[4] == crcrd_pkg::REC_VERSION)
               && (rb[6] == 8'd0) && (rb[7] == 8'd0);
  assign crc_ok = (crc_w == ~crc_r);

  // paused-until wins when codes coincide
  always_comb begin
    if (rb[5] == codes.paused_until) begin
      mode_ok = (epoch_w != 32'd0);
    end else if ((rb[5] == codes.enabled) || (rb[5] == codes.paused_forever)) begin
      mode_ok = (epoch_w == 32'd0);
    end else begin
      mode_ok = 1'b0;
    end
  end

  always_comb begin
    res = '0;
    if (len_ok && hdr_ok && crc_ok && mode_ok) begin
      res.record_ok     = 1'b1;
      res.mode_code     = rb[5];
      res.resume_epoch  = epoch_w;
      res.current_day   = {rb[15], rb[14], rb[13], rb[12]};
      res.current_mask  = {rb[19], rb[18], rb[17], rb[16]};
      res.previous_day  = {rb[23], rb[22], rb[21], rb[20]};
      res.previous_mask = {rb[27], rb[26], rb[25], rb[24]};
    end
  end

  assign res_valid = fire && beat.last_byte;

endmodule
`default_nettype wire

/* rtl/core/crcrd_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_out_reg
// result register, holds a word until the sink takes it
// ----------------------------------------------------------------------------
module crcrd_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire crcrd_pkg::result_t res,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output crcrd_pkg::result_t      out_res
);

  logic               valid_r;
  crcrd_pkg::result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* rtl/core/crcrd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_checker
// port-level checks on the record decoder, bound to the top level
// ----------------------------------------------------------------------------
module crcrd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [167:0] out_tdata,
  input wire logic [0:0]   out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // rejected record carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected record with nonzero fields");

  // empty result register never back-pressures input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result register empty");

  // nothing pending right after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind crc32_record_decoder crcrd_checker u_crcrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
